// File: sv/pwag_pkg.sv
// Shared types, constants and arithmetic helpers for the perspective warp address generator.
package pwag_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 8;
   localparam int SIZE_W     = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int COEF_W     = 32;
   localparam int PROD_W     = COEF_W + COORD_BITS + 1;
   localparam int NUM_W      = PROD_W + 2;
   localparam int NLOW_W     = 11;
   localparam int QUOT_W     = 21 + FRAC_BITS;
   localparam int RND_W      = QUOT_W - FRAC_BITS + 1;
   localparam int CMP_W      = QUOT_W + SIZE_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_AB    = 3'd0,
      CSR_COEF_DE    = 3'd1,
      CSR_COEF_CF    = 3'd2,
      CSR_COEF_GH    = 3'd3,
      CSR_SRC_WIDTH  = 3'd4,
      CSR_SRC_HEIGHT = 3'd5,
      CSR_BILINEAR   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] dst_x;
      logic [COORD_BITS-1:0] dst_y;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [COORD_BITS-1:0] src_col;
      logic [COORD_BITS-1:0] src_row;
      logic [FRAC_BITS-1:0]  frac_col;
      logic [FRAC_BITS-1:0]  frac_row;
      logic [COORD_BITS-1:0] dst_col;
      logic [COORD_BITS-1:0] dst_row;
   } rsp_type;

   typedef struct packed {
      logic              sat;
      logic [NUM_W-1:0]  rem;
      logic [NLOW_W-1:0] nlow;
      logic [QUOT_W-1:0] q;
   } div_lane_type;

   typedef struct packed {
      logic                  den_zero;
      logic                  neg_x;
      logic                  neg_y;
      logic [COORD_BITS-1:0] dst_x;
      logic [COORD_BITS-1:0] dst_y;
   } div_side_type;

   typedef struct packed {
      logic              neg;
      logic              inexact;
      logic [QUOT_W-1:0] mag;
      logic [RND_W-1:0]  rm;
   } fin_type;

   typedef struct packed {
      logic                  hit;
      logic [COORD_BITS-1:0] ip;
      logic [FRAC_BITS-1:0]  fp;
   } place_type;

   function automatic div_lane_type div_init(logic [NUM_W-1:0] n, logic [NUM_W-1:0] d);
      div_lane_type o;
      o.rem  = NUM_W'(n >> NLOW_W);
      o.sat  = (o.rem >= d);
      o.nlow = n[NLOW_W-1:0];
      o.q    = '0;
      return o;
   endfunction

   function automatic div_lane_type div_step(div_lane_type l, logic [NUM_W-1:0] d);
      logic [NUM_W:0] r2;
      logic [NUM_W:0] diff;
      div_lane_type   o;
      r2     = {l.rem, l.nlow[NLOW_W-1]};
      diff   = r2 - {1'b0, d};
      o      = l;
      o.nlow = {l.nlow[NLOW_W-2:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
         o.rem = diff[NUM_W-1:0];
         o.q   = {l.q[QUOT_W-2:0], 1'b1};
      end else begin
         o.rem = r2[NUM_W-1:0];
         o.q   = {l.q[QUOT_W-2:0], 1'b0};
      end
      return o;
   endfunction

   function automatic fin_type div_finish(div_lane_type l, logic neg);
      logic              sat;
      logic [QUOT_W:0]   rsum;
      fin_type           o;
      sat       = l.sat || (l.q[QUOT_W-1] && (l.q[QUOT_W-2:0] != '0));
      o.neg     = neg;
      o.inexact = sat || (l.rem != '0);
      o.mag     = sat ? (QUOT_W'(1) << (QUOT_W - 1)) : l.q;
      rsum      = {1'b0, o.mag} + ((QUOT_W + 1)'(1) << (FRAC_BITS - 1));
      o.rm      = rsum[QUOT_W:FRAC_BITS];
      return o;
   endfunction

   function automatic place_type place(fin_type f, logic [SIZE_W-1:0] size, logic bil);
      logic [SIZE_W-1:0] eff;
      logic [SIZE_W-1:0] lim;
      place_type         o;
      lim = SIZE_W'(1) << COORD_BITS;
      eff = (size > lim) ? lim : size;
      o   = '0;
      if (bil) begin
         o.hit = !(f.neg && ((f.mag != '0) || f.inexact)) &&
                 (CMP_W'(f.mag) < (CMP_W'(eff) << FRAC_BITS));
         o.ip  = f.mag[FRAC_BITS +: COORD_BITS];
         o.fp  = f.mag[FRAC_BITS-1:0];
      end else begin
         o.hit = !(f.neg && (f.rm != '0)) && (CMP_W'(f.rm) < CMP_W'(eff));
         o.ip  = f.rm[COORD_BITS-1:0];
      end
      return o;
   endfunction

endpackage

// File: sv/pwag_divider.sv
// Pipelined two-lane restoring divider, one quotient bit per stage.
module pwag_divider
   import pwag_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_nx,
   input  logic [NUM_W-1:0] in_ny,
   input  logic [NUM_W-1:0] in_d,
   input  div_side_type     in_side,
   output logic             out_valid,
   output div_lane_type     out_x,
   output div_lane_type     out_y,
   output div_side_type     out_side
);

   logic         valid_ff [QUOT_W+1];
   div_lane_type lx_ff    [QUOT_W+1];
   div_lane_type ly_ff    [QUOT_W+1];
   logic [NUM_W-1:0] d_ff [QUOT_W+1];
   div_side_type side_ff  [QUOT_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QUOT_W; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i <= QUOT_W; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lx_ff[0]   <= div_init(in_nx, in_d);
         ly_ff[0]   <= div_init(in_ny, in_d);
         d_ff[0]    <= in_d;
         side_ff[0] <= in_side;
         for (int i = 1; i <= QUOT_W; i++) begin
            lx_ff[i]   <= div_step(lx_ff[i-1], d_ff[i-1]);
            ly_ff[i]   <= div_step(ly_ff[i-1], d_ff[i-1]);
            d_ff[i]    <= d_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W];
   assign out_x     = lx_ff[QUOT_W];
   assign out_y     = ly_ff[QUOT_W];
   assign out_side  = side_ff[QUOT_W];

endmodule

// File: sv/perspective_warp_address_gen.sv
// Top level of the perspective warp address generator.
//
//   channel   direction  handshake              beat
//   req_      in         req_valid / req_stall  req_data  (dst_x, dst_y)
//   rsp_      out        rsp_valid / rsp_stall  rsp_data  (hit, source address, fractions)
//   csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// One beat enters per cycle while no stalled result is held, and the divider retires
// one quotient bit per stage.
// Reset is synchronous and clears all valid bits and restores the identity map.
// A stalled result freezes the whole pipeline, so req_stall follows rsp_stall
// while a result is held; nothing is dropped or repeated.
module perspective_warp_address_gen
   import pwag_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic signed [NUM_W-1:0] DEN_ONE = NUM_W'(64'd1 << 30);

   logic [CSR_DATA_W-1:0] coef_ab_ff, coef_de_ff, coef_cf_ff, coef_gh_ff;
   logic [SIZE_W-1:0]     src_width_ff, src_height_ff;
   logic                  bilinear_ff;

   logic advance;

   logic    s0_valid_ff;
   req_type s0_data_ff;

   logic                     s1_valid_ff;
   logic signed [PROD_W-1:0] ax_ff, by_ff, dx_ff, ey_ff, gx_ff, hy_ff;
   logic signed [COEF_W-1:0] c_ff, f_ff;
   req_type                  s1_data_ff;

   logic                    s2_valid_ff;
   logic signed [NUM_W-1:0] numx_ff, numy_ff, den_ff;
   req_type                 s2_data_ff;

   logic             s3_valid_ff;
   logic [NUM_W-1:0] nx_ff, ny_ff, d_ff;
   div_side_type     s3_side_ff;

   logic         dv_valid;
   div_lane_type dv_x, dv_y;
   div_side_type dv_side;

   logic         s4_valid_ff;
   fin_type      fx_ff, fy_ff;
   div_side_type s4_side_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic signed [COORD_BITS:0] xs, ys;
   logic signed [NUM_W-1:0]    numx_in, numy_in, den_in;
   place_type                  px, py;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ab_ff    <= CSR_DATA_W'(64'd1 << 20);
         coef_de_ff    <= CSR_DATA_W'(64'd1 << 52);
         coef_cf_ff    <= '0;
         coef_gh_ff    <= '0;
         src_width_ff  <= SIZE_W'(1);
         src_height_ff <= SIZE_W'(1);
         bilinear_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_COEF_AB:    coef_ab_ff    <= csr_data;
            CSR_COEF_DE:    coef_de_ff    <= csr_data;
            CSR_COEF_CF:    coef_cf_ff    <= csr_data;
            CSR_COEF_GH:    coef_gh_ff    <= csr_data;
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data[SIZE_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_data[SIZE_W-1:0];
            CSR_BILINEAR:   bilinear_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= req_valid;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= dv_valid;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   assign xs = $signed({1'b0, s0_data_ff.dst_x});
   assign ys = $signed({1'b0, s0_data_ff.dst_y});

   assign numx_in = NUM_W'(ax_ff) + NUM_W'(by_ff) + NUM_W'($signed({c_ff, 8'b0}));
   assign numy_in = NUM_W'(dx_ff) + NUM_W'(ey_ff) + NUM_W'($signed({f_ff, 8'b0}));
   assign den_in  = NUM_W'(gx_ff) + NUM_W'(hy_ff) + DEN_ONE;

   assign px = place(fx_ff, src_width_ff, bilinear_ff);
   assign py = place(fy_ff, src_height_ff, bilinear_ff);

   always_comb begin
      rsp_data_in         = '0;
      rsp_data_in.dst_col = s4_side_ff.dst_x;
      rsp_data_in.dst_row = s4_side_ff.dst_y;
      if (!s4_side_ff.den_zero && px.hit && py.hit) begin
         rsp_data_in.hit      = 1'b1;
         rsp_data_in.src_col  = px.ip;
         rsp_data_in.src_row  = py.ip;
         rsp_data_in.frac_col = px.fp;
         rsp_data_in.frac_row = py.fp;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_data_ff <= req_data;

         ax_ff      <= $signed(coef_ab_ff[31:0])  * xs;
         by_ff      <= $signed(coef_ab_ff[63:32]) * ys;
         dx_ff      <= $signed(coef_de_ff[31:0])  * xs;
         ey_ff      <= $signed(coef_de_ff[63:32]) * ys;
         gx_ff      <= $signed(coef_gh_ff[31:0])  * xs;
         hy_ff      <= $signed(coef_gh_ff[63:32]) * ys;
         c_ff       <= $signed(coef_cf_ff[31:0]);
         f_ff       <= $signed(coef_cf_ff[63:32]);
         s1_data_ff <= s0_data_ff;

         numx_ff    <= numx_in;
         numy_ff    <= numy_in;
         den_ff     <= den_in;
         s2_data_ff <= s1_data_ff;

         nx_ff               <= numx_ff[NUM_W-1] ? NUM_W'(-numx_ff) : NUM_W'(numx_ff);
         ny_ff               <= numy_ff[NUM_W-1] ? NUM_W'(-numy_ff) : NUM_W'(numy_ff);
         d_ff                <= den_ff[NUM_W-1]  ? NUM_W'(-den_ff)  : NUM_W'(den_ff);
         s3_side_ff.den_zero <= (den_ff == '0);
         s3_side_ff.neg_x    <= (numx_ff[NUM_W-1] != den_ff[NUM_W-1]) && (numx_ff != '0);
         s3_side_ff.neg_y    <= (numy_ff[NUM_W-1] != den_ff[NUM_W-1]) && (numy_ff != '0);
         s3_side_ff.dst_x    <= s2_data_ff.dst_x;
         s3_side_ff.dst_y    <= s2_data_ff.dst_y;

         fx_ff      <= div_finish(dv_x, dv_side.neg_x);
         fy_ff      <= div_finish(dv_y, dv_side.neg_y);
         s4_side_ff <= dv_side;

         rsp_data_ff <= rsp_data_in;
      end
   end

   pwag_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s3_valid_ff),
      .in_nx     (nx_ff),
      .in_ny     (ny_ff),
      .in_d      (d_ff),
      .in_side   (s3_side_ff),
      .out_valid (dv_valid),
      .out_x     (dv_x),
      .out_y     (dv_y),
      .out_side  (dv_side)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sv/pwag_checker.sv
// Port-level assertions for the perspective warp address generator and their binding.
module pwag_checker
   import pwag_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input req_type               req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_data,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result beat changed.");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.src_col == '0 && rsp_data.src_row == '0 &&
                                     rsp_data.frac_col == '0 && rsp_data.frac_row == '0)
      else $error("Missed beat carries a nonzero source address.");

   a_back_pressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("Input stall does not follow the held result.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result beat shown right after reset.");

endmodule

bind perspective_warp_address_gen pwag_checker u_checker (.*);
